// File: sv/twct_pkg.sv
package twct_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int STEP_W        = 32;
    localparam int POS_W         = 26;
    localparam int AGE_W         = 40;
    localparam int CNT_W         = 10;
    localparam int CELL_W        = 11;
    localparam int KIND_W        = 3;
    localparam int ALU_W         = 35;
    localparam int DIV_W         = 32;
    localparam int TDATA_W       = 80;
    localparam int TUSER_W       = 4;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int DEF_MAX_CELLS = 1024;
    localparam int RING_RESET    = 1024;
    localparam int MIN_CELLS     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSIDE  = 3'd0,
        KIND_WRAP_UP = 3'd1,
        KIND_OVER_UP = 3'd2,
        KIND_WRAP_DN = 3'd3,
        KIND_OVER_DN = 3'd4
    } kind_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
        logic             zero;
    } alu_res_t;

endpackage

// File: sv/twct_ram.sv
module twct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = twct_pkg::DEF_MAX_CELLS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/twct_alu.sv
module twct_alu (
    input  twct_pkg::alu_op_t              op,
    input  logic [twct_pkg::ALU_W-1:0]     a,
    input  logic [twct_pkg::ALU_W-1:0]     b,
    output twct_pkg::alu_res_t             res
);

    import twct_pkg::*;

    logic [ALU_W-1:0] sum;

    always_comb begin
        unique case (op)
            ALU_ADD: sum = a + b;
            ALU_SUB: sum = a - b;
            default: sum = a + b;
        endcase
    end

    assign res.sum  = sum;
    assign res.neg  = sum[ALU_W-1];
    assign res.zero = (sum == '0);

endmodule

// File: sv/torus_walk_coverage_tracker.sv
// one item at a time; s_tready is high only while the sequencer is idle
// step inside the ring: add, compare, then each cell swept is read and marked
// single wrap: two mark ranges, one cycle per cell each
// overshoot: the remainder takes 32 passes of the shared adder
// reset, restart and ring_cells write: clearing pass over every ring cell of
// the visited map (1024 after reset), cell 0 marked, before the next item is taken
module torus_walk_coverage_tracker #(
    parameter int MAX_CELLS = twct_pkg::DEF_MAX_CELLS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [twct_pkg::STEP_W-1:0]    s_tdata,   // step_value
    input  logic                           s_tuser,   // restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [twct_pkg::TDATA_W-1:0]   m_tdata,   // wrapped_position, age, cells_left
    output logic [twct_pkg::TUSER_W-1:0]   m_tuser,   // crossing_kind, done_cause
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [twct_pkg::APB_AW-1:0]    paddr,
    input  logic [twct_pkg::APB_DW-1:0]    pwdata,
    output logic [twct_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import twct_pkg::*;

    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam int DCW   = $clog2(DIV_W);
    localparam logic [CELL_W-1:0] MAX_SZ = CELL_W'(MAX_CELLS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_ADD, ST_SUBS, ST_ADDS, ST_CMPO,
        ST_NEG, ST_DIV, ST_FIX, ST_MRD, ST_MCK, ST_OUT
    } state_t;

    function automatic logic [CELL_W-1:0] clamp_size(input logic [CELL_W-1:0] v);
        logic [CELL_W-1:0] r;
        if (v < CELL_W'(MIN_CELLS)) begin
            r = CELL_W'(MIN_CELLS);
        end else if (int'(v) > MAX_CELLS) begin
            r = MAX_SZ;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [ALU_W-1:0] x);
        return x[FRAC_BITS+CELL_W-1:FRAC_BITS];
    endfunction

    state_t              state_reg;
    logic [CELL_W-1:0]   ring_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [AGE_W-1:0]    age_reg;
    logic                fin_reg;
    kind_t               kind_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ALU_W-1:0]    now_reg;
    logic [ALU_W-1:0]    t_reg;
    logic [ALU_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    q_reg;
    logic [DCW-1:0]      div_cnt_reg;
    logic [CELL_W-1:0]   cur_reg;
    logic [CELL_W-1:0]   end_reg;
    logic [CELL_W-1:0]   b_lo_reg;
    logic [CELL_W-1:0]   b_hi_reg;
    logic                two_reg;
    logic [CELL_W-1:0]   clr_reg;
    logic                clr_out_reg;
    logic                m_valid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;
    logic [TUSER_W-1:0]  m_tuser_reg;
    logic                m_tlast_reg;

    logic [CELL_W-1:0]   sz;
    logic [CELL_W-1:0]   last;
    logic [ALU_W-1:0]    sfix;
    logic [ALU_W-1:0]    old_ext;
    logic [ALU_W-1:0]    step_ext;
    logic [ALU_W-1:0]    trial;
    logic                now_neg;
    logic                step_neg;
    logic [CELL_W-1:0]   lo_cell;
    logic [CELL_W-1:0]   hi_raw;
    logic [CELL_W-1:0]   hi_cell;
    logic [CELL_W-1:0]   cur_inc;
    logic [CNT_W-1:0]    cnt_dec;
    logic                cfg_we;
    logic                cfg_hit;
    logic                s_accept;
    logic                m_load;

    alu_op_t             alu_op;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    alu_res_t            alu_res;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic                ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic                ram_rdata;

    assign sz       = clamp_size(ring_reg);
    assign last     = sz - CELL_W'(1);
    assign sfix     = ALU_W'({sz, {FRAC_BITS{1'b0}}});
    assign old_ext  = ALU_W'(pos_reg);
    assign step_ext = {{(ALU_W-STEP_W){step_reg[STEP_W-1]}}, step_reg};
    assign trial    = {rem_reg[ALU_W-2:0], q_reg[DIV_W-1]};
    assign now_neg  = now_reg[ALU_W-1];
    assign step_neg = step_reg[STEP_W-1];
    assign lo_cell  = cell_of(step_neg ? now_reg : old_ext);
    assign hi_raw   = cell_of(step_neg ? old_ext : now_reg);
    assign hi_cell  = (hi_raw > last) ? last : hi_raw;
    assign cur_inc  = cur_reg + CELL_W'(1);
    assign cnt_dec  = (!ram_rdata && cnt_reg != '0) ? cnt_reg - CNT_W'(1) : cnt_reg;

    assign cfg_we   = psel & penable & pwrite;
    assign cfg_hit  = cfg_we & ~paddr[2];
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? '0 : APB_DW'(ring_reg);

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign s_accept = s_tvalid & s_tready;
    assign m_load   = (state_reg == ST_OUT) && !cfg_hit && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = now_reg;
        alu_b  = sfix;
        unique case (state_reg)
            ST_ADD: begin
                alu_a = old_ext;
                alu_b = step_ext;
            end
            ST_SUBS: alu_op = ALU_SUB;
            ST_CMPO: begin
                alu_op = ALU_SUB;
                alu_a  = t_reg;
                alu_b  = old_ext;
            end
            ST_NEG: begin
                alu_op = ALU_SUB;
                alu_a  = '0;
                alu_b  = now_reg;
            end
            ST_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = trial;
            end
            ST_FIX: begin
                alu_op = ALU_SUB;
                alu_a  = sfix;
                alu_b  = rem_reg;
            end
            default: alu_op = ALU_ADD;
        endcase
    end

    twct_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    always_comb begin
        ram_we    = (state_reg == ST_CLR) || (state_reg == ST_MCK && !ram_rdata);
        ram_waddr = (state_reg == ST_CLR) ? clr_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
        ram_wdata = (state_reg == ST_CLR) ? (clr_reg == '0) : 1'b1;
        ram_raddr = (state_reg == ST_MCK) ? cur_inc[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    end

    twct_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_visited (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            ring_reg    <= CELL_W'(RING_RESET);
            pos_reg     <= '0;
            cnt_reg     <= CNT_W'(clamp_size(CELL_W'(RING_RESET)) - CELL_W'(1));
            age_reg     <= '0;
            fin_reg     <= 1'b0;
            kind_reg    <= KIND_INSIDE;
            two_reg     <= 1'b0;
            clr_reg     <= '0;
            clr_out_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_hit) begin
                ring_reg    <= pwdata[CELL_W-1:0];
                pos_reg     <= '0;
                cnt_reg     <= CNT_W'(clamp_size(pwdata[CELL_W-1:0]) - CELL_W'(1));
                age_reg     <= '0;
                fin_reg     <= 1'b0;
                clr_reg     <= '0;
                clr_out_reg <= 1'b0;
                state_reg   <= ST_CLR;
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (s_accept) begin
                            kind_reg <= KIND_INSIDE;
                            if (s_tuser) begin
                                pos_reg     <= '0;
                                age_reg     <= '0;
                                fin_reg     <= 1'b0;
                                cnt_reg     <= CNT_W'(last);
                                clr_reg     <= '0;
                                clr_out_reg <= 1'b1;
                                state_reg   <= ST_CLR;
                            end else if (fin_reg) begin
                                state_reg <= ST_OUT;
                            end else begin
                                step_reg  <= s_tdata;
                                state_reg <= ST_ADD;
                            end
                        end
                    end
                    ST_CLR: begin
                        if (clr_reg == last) begin
                            state_reg <= clr_out_reg ? ST_OUT : ST_IDLE;
                        end else begin
                            clr_reg <= clr_reg + CELL_W'(1);
                        end
                    end
                    ST_ADD: begin
                        now_reg <= alu_res.sum;
                        if (age_reg != '1) begin
                            age_reg <= age_reg + AGE_W'(1);
                        end
                        state_reg <= ST_SUBS;
                    end
                    ST_SUBS: begin
                        t_reg <= alu_res.sum;
                        if (!now_neg && (alu_res.neg || alu_res.zero)) begin
                            kind_reg  <= KIND_INSIDE;
                            pos_reg   <= alu_res.zero ? '0 : now_reg[POS_W-1:0];
                            cur_reg   <= lo_cell;
                            end_reg   <= hi_cell;
                            two_reg   <= 1'b0;
                            state_reg <= ST_MRD;
                        end else if (!now_neg) begin
                            state_reg <= ST_CMPO;
                        end else begin
                            state_reg <= ST_ADDS;
                        end
                    end
                    ST_ADDS: begin
                        t_reg     <= alu_res.sum;
                        state_reg <= ST_CMPO;
                    end
                    ST_CMPO: begin
                        if (!now_neg) begin
                            if (alu_res.neg || alu_res.zero) begin
                                kind_reg  <= KIND_WRAP_UP;
                                pos_reg   <= t_reg[POS_W-1:0];
                                cur_reg   <= '0;
                                end_reg   <= cell_of(t_reg);
                                b_lo_reg  <= cell_of(old_ext);
                                b_hi_reg  <= last;
                                two_reg   <= 1'b1;
                                state_reg <= ST_MRD;
                            end else begin
                                kind_reg  <= KIND_OVER_UP;
                                state_reg <= ST_NEG;
                            end
                        end else begin
                            if (!alu_res.neg) begin
                                kind_reg  <= KIND_WRAP_DN;
                                pos_reg   <= t_reg[POS_W-1:0];
                                cur_reg   <= '0;
                                end_reg   <= cell_of(old_ext);
                                b_lo_reg  <= cell_of(t_reg);
                                b_hi_reg  <= last;
                                two_reg   <= 1'b1;
                                state_reg <= ST_MRD;
                            end else begin
                                kind_reg  <= KIND_OVER_DN;
                                state_reg <= ST_NEG;
                            end
                        end
                    end
                    ST_NEG: begin
                        q_reg       <= now_neg ? alu_res.sum[DIV_W-1:0] : now_reg[DIV_W-1:0];
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                    ST_DIV: begin
                        rem_reg <= alu_res.neg ? trial : alu_res.sum;
                        q_reg   <= {q_reg[DIV_W-2:0], 1'b0};
                        if (div_cnt_reg == DCW'(DIV_W - 1)) begin
                            state_reg <= ST_FIX;
                        end else begin
                            div_cnt_reg <= div_cnt_reg + DCW'(1);
                        end
                    end
                    ST_FIX: begin
                        pos_reg   <= (now_neg && rem_reg != '0) ? alu_res.sum[POS_W-1:0]
                                                                : rem_reg[POS_W-1:0];
                        fin_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    ST_MRD: begin
                        state_reg <= ST_MCK;
                    end
                    ST_MCK: begin
                        cnt_reg <= cnt_dec;
                        if (cur_reg == end_reg) begin
                            if (two_reg) begin
                                cur_reg   <= b_lo_reg;
                                end_reg   <= b_hi_reg;
                                two_reg   <= 1'b0;
                                state_reg <= ST_MRD;
                            end else begin
                                fin_reg   <= (cnt_dec == '0);
                                state_reg <= ST_OUT;
                            end
                        end else begin
                            cur_reg <= cur_inc;
                        end
                    end
                    ST_OUT: begin
                        if (m_load) begin
                            m_valid_reg <= 1'b1;
                            m_tdata_reg <= TDATA_W'({cnt_reg, age_reg, pos_reg});
                            m_tuser_reg <= {fin_reg && (cnt_reg != '0), kind_reg};
                            m_tlast_reg <= fin_reg;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

endmodule
